@@ rtl/enig_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package enig_pkg;

  localparam int unsigned AlphabetSize = 26;
  localparam int unsigned LetterW      = 5;

  typedef logic [LetterW-1:0] letter_t;
  typedef letter_t tab_t [AlphabetSize];

  typedef struct packed {
    letter_t left;
    letter_t middle;
    letter_t right;
  } pos_t;

  // configuration register indexes
  localparam logic [1:0] REG_LEFT_START   = 2'd0;
  localparam logic [1:0] REG_MIDDLE_START = 2'd1;
  localparam logic [1:0] REG_RIGHT_START  = 2'd2;

  // request action codes
  localparam logic ACT_CIPHER  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam letter_t LEFT_START_RST   = 5'd2;
  localparam letter_t MIDDLE_START_RST = 5'd21;
  localparam letter_t RIGHT_START_RST  = 5'd17;

  localparam letter_t LAST_LETTER = letter_t'(AlphabetSize - 1);

  localparam tab_t REFL = '{
    5'd24, 5'd17, 5'd20, 5'd7,  5'd16, 5'd18, 5'd11, 5'd3,  5'd15, 5'd23, 5'd13, 5'd6,  5'd14,
    5'd10, 5'd12, 5'd8,  5'd4,  5'd1,  5'd5,  5'd25, 5'd2,  5'd22, 5'd21, 5'd9,  5'd0,  5'd19};

  localparam tab_t ROT_L = '{
    5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd2,  5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4,  5'd8,  5'd22, 5'd6,  5'd0,  5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
  localparam tab_t ROT_M = '{
    5'd0,  5'd9,  5'd3,  5'd10, 5'd18, 5'd8,  5'd17, 5'd20, 5'd23, 5'd1,  5'd11, 5'd7,  5'd22,
    5'd19, 5'd12, 5'd2,  5'd16, 5'd6,  5'd25, 5'd13, 5'd15, 5'd24, 5'd5,  5'd21, 5'd14, 5'd4};
  localparam tab_t ROT_R = '{
    5'd4,  5'd10, 5'd12, 5'd5,  5'd11, 5'd6,  5'd3,  5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7,  5'd23, 5'd20, 5'd18, 5'd15, 5'd0,  5'd8,  5'd1,  5'd17, 5'd2,  5'd9};

  // inverse wirings for the return path
  localparam tab_t INV_L = '{
    5'd19, 5'd0,  5'd6,  5'd1,  5'd15, 5'd2,  5'd18, 5'd3,  5'd16, 5'd4,  5'd20, 5'd5,  5'd21,
    5'd13, 5'd25, 5'd7,  5'd24, 5'd8,  5'd23, 5'd9,  5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};
  localparam tab_t INV_M = '{
    5'd0,  5'd9,  5'd15, 5'd2,  5'd25, 5'd22, 5'd17, 5'd11, 5'd5,  5'd1,  5'd3,  5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6,  5'd4,  5'd13, 5'd7,  5'd23, 5'd12, 5'd8,  5'd21, 5'd18};
  localparam tab_t INV_R = '{
    5'd20, 5'd22, 5'd24, 5'd6,  5'd0,  5'd3,  5'd5,  5'd15, 5'd21, 5'd25, 5'd1,  5'd4,  5'd2,
    5'd10, 5'd12, 5'd19, 5'd7,  5'd23, 5'd18, 5'd11, 5'd17, 5'd8,  5'd13, 5'd16, 5'd14, 5'd9};

  // reduce a raw 5-bit value into 0..25
  function automatic letter_t fold(input letter_t v);
    return (v >= letter_t'(AlphabetSize)) ? letter_t'(v - letter_t'(AlphabetSize)) : v;
  endfunction

  function automatic letter_t add_mod(input letter_t a, input letter_t b);
    logic [LetterW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LetterW+1)'(AlphabetSize)) begin
      s = s - (LetterW+1)'(AlphabetSize);
    end
    return s[LetterW-1:0];
  endfunction

  function automatic letter_t sub_mod(input letter_t a, input letter_t b);
    letter_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = letter_t'(a + letter_t'(AlphabetSize) - b);
    end
    return r;
  endfunction

  // one rotor passage: wiring offset by the rotor position
  function automatic letter_t rotor_pass(input tab_t w, input letter_t p, input letter_t x);
    return sub_mod(w[add_mod(x, p)], p);
  endfunction

  function automatic letter_t step_one(input letter_t p);
    return (p == LAST_LETTER) ? '0 : letter_t'(p + letter_t'(1));
  endfunction

endpackage

`default_nettype wire

@@ rtl/enig_pos_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rotor position store: one-entry synchronous memory, read every cycle,
// with the last write forwarded for the cycle in which the read is stale.
module enig_pos_store (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire enig_pkg::pos_t wr_pos_i,
  input  wire enig_pkg::pos_t rst_pos_i,
  output enig_pkg::pos_t      rd_pos_o
);
  import enig_pkg::*;

  pos_t mem_q [1];
  pos_t rd_q;
  pos_t fwd_q;
  logic fwd_vld_q;
  logic mem_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[0] <= wr_pos_i;
      fwd_q    <= wr_pos_i;
    end
    rd_q <= mem_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
      mem_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en_i;
      if (wr_en_i) begin
        mem_vld_q <= 1'b1;
      end
    end
  end

  // until the first write the entry reads as the reset positions
  assign rd_pos_o = fwd_vld_q ? fwd_q : (mem_vld_q ? rd_q : rst_pos_i);

endmodule

`default_nettype wire

@@ rtl/three_rotor_enigma_cipher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        request    in_valid_i/in_stall_o action_i, letter_in_i
// out       result     out_valid_o/out_stall_i letter_out_o
// cfg       write      cfg_we_i              cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while out is not stalled; once accepted, a
// letter passes two more pass stages and the output register. Rotor positions
// live in a one-entry memory with a registered read; the forward path covers
// back-to-back updates. A restart request updates positions and gives no
// result. Reset loads start registers 2/21/17 and empties the pipe.
// A stall on out backs up the stages and then stalls in.
module three_rotor_enigma_cipher_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 action_i,
  input  wire enig_pkg::letter_t    letter_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output enig_pkg::letter_t         letter_out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire enig_pkg::letter_t    cfg_data_i
);
  import enig_pkg::*;

  // configuration
  letter_t left_start_q, middle_start_q, right_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_start_q   <= LEFT_START_RST;
      middle_start_q <= MIDDLE_START_RST;
      right_start_q  <= RIGHT_START_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT_START:   left_start_q   <= cfg_data_i;
        REG_MIDDLE_START: middle_start_q <= cfg_data_i;
        REG_RIGHT_START:  right_start_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_act_q;
  logic en1, en2, en3, en4, s1_go, s1_cipher;

  assign en4       = !out_v_q || !out_stall_i;
  assign en3       = !s3_v_q || en4;
  assign en2       = !s2_v_q || en3;
  assign s1_cipher = s1_v_q && (s1_act_q == ACT_CIPHER);
  assign s1_go     = s1_v_q && ((s1_act_q == ACT_RESTART) || en2);
  assign en1       = !s1_v_q || s1_go;
  assign in_stall_o = !en1;

  // position store, read-modify-write as a request leaves stage 1
  pos_t pos_cur, pos_d, pos_rst, pos_load;

  assign pos_rst  = '{left: fold(LEFT_START_RST), middle: fold(MIDDLE_START_RST),
                      right: fold(RIGHT_START_RST)};
  assign pos_load = '{left: fold(left_start_q), middle: fold(middle_start_q),
                      right: fold(right_start_q)};

  always_comb begin
    pos_d       = pos_cur;
    pos_d.right = step_one(pos_cur.right);
    if (pos_cur.right == LAST_LETTER) begin
      pos_d.middle = step_one(pos_cur.middle);
      if (pos_cur.middle == LAST_LETTER) begin
        pos_d.left = step_one(pos_cur.left);
      end
    end
    if (s1_act_q == ACT_RESTART) begin
      pos_d = pos_load;
    end
  end

  enig_pos_store u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s1_go),
    .wr_pos_i  (pos_d),
    .rst_pos_i (pos_rst),
    .rd_pos_o  (pos_cur)
  );

  // datapath registers
  letter_t s1_let_q, s2_x_q, s3_x_q, out_q;
  pos_t    s2_pos_q, s3_pos_q;
  letter_t s1_x, s2_x, s3_x;

  assign s1_x = rotor_pass(ROT_M, pos_cur.middle, rotor_pass(ROT_R, pos_cur.right, s1_let_q));
  assign s2_x = rotor_pass(INV_L, s2_pos_q.left,
                           REFL[rotor_pass(ROT_L, s2_pos_q.left, s2_x_q)]);
  assign s3_x = rotor_pass(INV_R, s3_pos_q.right, rotor_pass(INV_M, s3_pos_q.middle, s3_x_q));

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_act_q <= action_i;
      s1_let_q <= fold(letter_in_i);
    end
    if (en2) begin
      s2_x_q   <= s1_x;
      s2_pos_q <= pos_cur;
    end
    if (en3) begin
      s3_x_q   <= s2_x;
      s3_pos_q <= s2_pos_q;
    end
    if (en4) begin
      out_q <= s3_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= in_valid_i;
      if (en2) s2_v_q  <= s1_cipher;
      if (en3) s3_v_q  <= s2_v_q;
      if (en4) out_v_q <= s3_v_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign letter_out_o = out_q;

  // assertions
  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (letter_out_o < letter_t'(AlphabetSize)))
    else $error("cipher letter out of range");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && s3_v_q && out_v_q))
    else $error("input stalled with a free stage");

  a_cipher_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_cipher) |=> s2_v_q)
    else $error("cipher request lost between stages");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (pos_cur.left < letter_t'(AlphabetSize)) &&
               (pos_cur.middle < letter_t'(AlphabetSize)) &&
               (pos_cur.right < letter_t'(AlphabetSize)))
    else $error("rotor position out of range");

endmodule

`default_nettype wire
